FILE: rtl/sobs_pkg.sv
package sobs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam logic [4:0] CAP_RESET = 5'd16;
    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_PUSH,
        ACT_POP,
        ACT_POP_AT,
        ACT_PEEK
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_BAD_INDEX,
        STAT_OVERFLOW
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK2,
        S_READ
    } ctrl_state_t;

    typedef struct packed {
        action_t                       action;
        logic signed [DATA_WIDTH-1:0]  push_value;
        logic [3:0]                    stack_index;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  read_value;
        status_t                       status;
        logic [4:0]                    live_stack_count;
    } rsp_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_op_t;

endpackage

FILE: rtl/sobs_store.sv
module sobs_store
    import sobs_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                  clk,
    input  mem_op_t               op,
    input  logic [AW-1:0]         addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (op.wr)
        begin
            mem[addr] <= wdata;
        end
        if (op.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sobs_ctrl.sv
module sobs_ctrl
    import sobs_pkg::*;
#(
    parameter int MAX_PLATES = 16,
    parameter int MAX_STACKS = 16,
    parameter int FW = 5,
    parameter int AW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cmd_t                  cmd,
    input  logic [FW-1:0]         cap,
    output logic                  busy,
    output logic                  done,
    output rsp_t                  rsp,
    output mem_op_t               mem_op,
    output logic [AW-1:0]         mem_addr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    input  logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CW = $clog2(MAX_STACKS + 1);

    ctrl_state_t   state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    rsp_t          rsp_reg, rsp_next;
    logic          done_reg, done_next;
    logic [CW-1:0] live_reg, live_next;
    logic [FW-1:0] fill_reg [MAX_STACKS];

    logic          f_we;
    logic [SW-1:0] f_waddr;
    logic [FW-1:0] f_wdata;
    logic [SW-1:0] f_raddr;
    logic [FW-1:0] f_rd;

    logic [SW-1:0] top_s;
    logic [8:0]    idx_w;
    logic [SW-1:0] idx_s;
    logic [CW-1:0] base_l;
    logic [SW-1:0] ptop;
    logic [FW-1:0] pfill;
    logic          push_ok;

    function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] s, input logic [FW-1:0] f);
        return AW'(AW'(s) * AW'(MAX_PLATES)) + AW'(f);
    endfunction

    assign top_s = SW'(live_reg - CW'(1));
    assign idx_w = 9'(cmd_reg.stack_index);
    assign idx_s = idx_w[SW-1:0];

    always_comb
    begin
        case (state_reg)
            S_EXEC:  f_raddr = (cmd_reg.action == ACT_POP_AT) ? idx_s : top_s;
            S_PEEK2: f_raddr = SW'(live_reg - CW'(2));
            default: f_raddr = top_s;
        endcase
    end

    assign f_rd = fill_reg[f_raddr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            live_reg  <= CW'(1);
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            live_reg  <= live_next;
            if (f_we)
            begin
                fill_reg[f_waddr] <= f_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        live_next  = live_reg;
        f_we       = 1'b0;
        f_waddr    = top_s;
        f_wdata    = '0;
        mem_op     = '0;
        mem_addr   = '0;
        mem_wdata  = cmd_reg.push_value;
        base_l     = live_reg;
        ptop       = top_s;
        pfill      = f_rd;
        push_ok    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (cmd_reg.action)
                    ACT_PUSH:
                    begin
                        base_l = (live_reg == '0) ? CW'(1) : live_reg;
                        ptop   = SW'(base_l - CW'(1));
                        pfill  = (live_reg == '0) ? '0 : f_rd;
                        live_next = base_l;
                        if (pfill >= cap)
                        begin
                            if (base_l < CW'(MAX_STACKS))
                            begin
                                ptop      = SW'(base_l);
                                pfill     = '0;
                                live_next = base_l + CW'(1);
                            end
                            else
                            begin
                                push_ok = 1'b0;
                            end
                        end
                        if (push_ok)
                        begin
                            mem_op.wr = 1'b1;
                            mem_addr  = word_addr(ptop, pfill);
                            f_we      = 1'b1;
                            f_waddr   = ptop;
                            f_wdata   = pfill + FW'(1);
                        end
                        rsp_next.read_value       = WORD_MIN;
                        rsp_next.status           = push_ok ? STAT_OK : STAT_OVERFLOW;
                        rsp_next.live_stack_count = 5'(live_next);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end

                    ACT_POP:
                    begin
                        if (live_reg == '0)
                        begin
                            rsp_next.read_value       = WORD_MIN;
                            rsp_next.status           = STAT_EMPTY;
                            rsp_next.live_stack_count = 5'(live_reg);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (f_rd == '0)
                        begin
                            // drop the empty trailing sub-stack and look again
                            live_next = live_reg - CW'(1);
                        end
                        else
                        begin
                            f_we      = 1'b1;
                            f_waddr   = top_s;
                            f_wdata   = f_rd - FW'(1);
                            mem_op.rd = 1'b1;
                            mem_addr  = word_addr(top_s, f_rd - FW'(1));
                            state_next = S_READ;
                        end
                    end

                    ACT_POP_AT:
                    begin
                        if (idx_w >= 9'(live_reg) || idx_w >= 9'(MAX_STACKS))
                        begin
                            rsp_next.read_value       = WORD_MIN;
                            rsp_next.status           = STAT_BAD_INDEX;
                            rsp_next.live_stack_count = 5'(live_reg);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (f_rd == '0)
                        begin
                            rsp_next.read_value       = WORD_MIN;
                            rsp_next.status           = STAT_EMPTY;
                            rsp_next.live_stack_count = 5'(live_reg);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            f_we      = 1'b1;
                            f_waddr   = idx_s;
                            f_wdata   = f_rd - FW'(1);
                            mem_op.rd = 1'b1;
                            mem_addr  = word_addr(idx_s, f_rd - FW'(1));
                            state_next = S_READ;
                        end
                    end

                    ACT_PEEK:
                    begin
                        if (live_reg != '0 && f_rd != '0)
                        begin
                            mem_op.rd  = 1'b1;
                            mem_addr   = word_addr(top_s, f_rd - FW'(1));
                            state_next = S_READ;
                        end
                        else if (live_reg > CW'(1))
                        begin
                            state_next = S_PEEK2;
                        end
                        else
                        begin
                            rsp_next.read_value       = WORD_MIN;
                            rsp_next.status           = STAT_EMPTY;
                            rsp_next.live_stack_count = 5'(live_reg);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_PEEK2:
            begin
                if (f_rd != '0)
                begin
                    mem_op.rd  = 1'b1;
                    mem_addr   = word_addr(f_raddr, f_rd - FW'(1));
                    state_next = S_READ;
                end
                else
                begin
                    rsp_next.read_value       = WORD_MIN;
                    rsp_next.status           = STAT_EMPTY;
                    rsp_next.live_stack_count = 5'(live_reg);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                rsp_next.read_value       = mem_rdata;
                rsp_next.status           = STAT_OK;
                rsp_next.live_stack_count = 5'(live_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result strobe without a transaction in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_EXEC)
        else $error("accepted transaction did not start execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MAX_STACKS))
        else $error("live sub-stack count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_op.wr && mem_op.rd))
        else $error("word store read and written in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == STAT_OVERFLOW) |-> live_reg == CW'(MAX_STACKS))
        else $error("overflow reported with a sub-stack still unopened");

endmodule

FILE: rtl/set_of_bounded_stacks.sv
// Set of bounded stacks: MAX_STACKS sub-stacks of up to plate_capacity words each (clamped
// to 1..MAX_PLATES), used together as one stack. A transaction is taken when start is high
// and busy is low; its one result appears on rsp for exactly one cycle with done high and
// must be captured then, since the block cannot be stalled. Pop, pop-at and peek of a word
// pass through a read state, as the word store is a synchronous memory with a registered
// read; peek that falls back to the sub-stack below the last also passes S_PEEK2, and pop
// revisits the execute state for each empty trailing sub-stack it drops. busy falls in the
// cycle done is shown, so a new transaction may be accepted there. The capacity register is
// written through cfg_valid/cfg_ready while idle.
module set_of_bounded_stacks
    import sobs_pkg::*;
#(
    parameter int MAX_PLATES = 16,
    parameter int MAX_STACKS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int DEPTH = MAX_STACKS * MAX_PLATES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(MAX_PLATES + 1);

    logic [4:0]            cap_reg;
    logic [8:0]            cap_w;
    logic [FW-1:0]         cap_eff;
    mem_op_t               mem_op;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign cfg_ready = ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    assign cap_w   = 9'(cap_reg);
    assign cap_eff = (cap_w == 9'd0)            ? FW'(1)
                   : (cap_w > 9'(MAX_PLATES))   ? FW'(MAX_PLATES)
                   :                              FW'(cap_w);

    sobs_ctrl #(
        .MAX_PLATES (MAX_PLATES),
        .MAX_STACKS (MAX_STACKS),
        .FW         (FW),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .cap       (cap_eff),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .mem_op    (mem_op),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    sobs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .op    (mem_op),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
